[rtl/wlcm_pkg.sv]
// Package for the weighted label co-occurrence matrix: widths, codes,
// reset values and the command and status structs between controller and datapath.
// No dependencies.
package wlcm_pkg;

	// Default matrix side length.
	localparam int MAX_LABELS_DEF = 128;

	// Field widths.
	localparam int LABEL_W    = 7;
	localparam int WEIGHT_W   = 16;
	localparam int PROD_W     = 32;
	localparam int ENTRY_W    = 48;
	localparam int TOTAL_W    = 56;
	localparam int NORM_W     = 33;
	localparam int QUOT_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Operation codes.
	localparam logic OP_ACCUMULATE = 1'b0;
	localparam logic OP_READ       = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_ACCUMULATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BELOW_CUT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUT_RANGE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_READ_DONE   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMALISE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF      = 2'd2;

	// Configuration reset values.
	localparam logic [COUNT_W-1:0]    LABEL_COUNT_RST = 8'd72;
	localparam logic                  NORMALISE_RST   = 1'b0;
	localparam logic [CFG_DATA_W-1:0] CUTOFF_RST      = 32'd0;

	// A fraction of one in Q1.32.
	localparam logic [NORM_W-1:0] NORM_ONE = 33'h1_0000_0000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // take the input item
		logic clr_step;   // write one zero entry of the clearing pass
		logic rd_rc;      // read entry [row][col]
		logic rd_cr;      // read entry [col][row]
		logic wr_rc;      // write back [row][col] and update the total
		logic wr_cr;      // write back [col][row]
		logic take_read;  // take the read data as the result entry
		logic div_start;  // start the fraction divider
		logic take_div;   // take the divider quotient
		logic load_out;   // load the output register
	} wlcm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic oor;        // a label is out of range
		logic is_read;    // the item is a read
		logic pass;       // the product exceeds the cutoff
		logic norm_need;  // a fraction must be returned
		logic norm_full;  // the entry is not below the total
		logic div_done;   // the divider has finished
		logic clr_last;   // the clearing pass is at its last entry
		logic out_free;   // the output register can take a result
	} wlcm_sts_t;

endpackage

[rtl/wlcm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wlcm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/wlcm_div.sv]
// Restoring divider giving a 32-bit fraction of an entry over the total, one bit a cycle.
// Depends on wlcm_pkg.
module wlcm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wlcm_pkg::ENTRY_W-1:0]  num,
	input  logic [wlcm_pkg::TOTAL_W-1:0]  den,
	output logic                          done,
	output logic [wlcm_pkg::QUOT_W-1:0]   quot
);
	import wlcm_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TOTAL_W-1:0]  rem_q;
	logic [TOTAL_W-1:0]  den_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [TOTAL_W:0]    shifted;
	logic                ge;
	logic [TOTAL_W-1:0]  rem_next;

	// One restoring step: the remainder stays below the divisor.
	always_comb begin
		shifted  = {rem_q, 1'b0};
		ge       = shifted >= {1'b0, den_q};
		rem_next = ge ? TOTAL_W'(shifted - {1'b0, den_q}) : shifted[TOTAL_W-1:0];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {{(TOTAL_W-ENTRY_W){1'b0}}, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[rtl/wlcm_dpath.sv]
// Datapath: configuration registers, item registers, matrix memory, total,
// saturating adders, fraction divider and output register.
// Depends on wlcm_pkg, wlcm_ram and wlcm_div.
module wlcm_dpath #(
	parameter int MAX_LABELS = wlcm_pkg::MAX_LABELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wlcm_pkg::wlcm_cmd_t             cmd,
	output wlcm_pkg::wlcm_sts_t             sts,
	input  logic                            operation,
	input  logic [wlcm_pkg::LABEL_W-1:0]    label_row,
	input  logic [wlcm_pkg::LABEL_W-1:0]    label_col,
	input  logic [wlcm_pkg::WEIGHT_W-1:0]   weight_row,
	input  logic [wlcm_pkg::WEIGHT_W-1:0]   weight_col,
	input  logic                            cfg_valid,
	input  logic [wlcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wlcm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [wlcm_pkg::STATUS_W-1:0]   status,
	output logic [wlcm_pkg::ENTRY_W-1:0]    entry_value,
	output logic [wlcm_pkg::TOTAL_W-1:0]    total_weight,
	output logic [wlcm_pkg::NORM_W-1:0]     normalised_value
);
	import wlcm_pkg::*;

	localparam int DEPTH = MAX_LABELS * MAX_LABELS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [31:0] MAX_L = 32'(MAX_LABELS);

	// Configuration.
	logic [COUNT_W-1:0]    label_count_q;
	logic                  normalise_q;
	logic [PROD_W-1:0]     cutoff_q;

	// Item being processed.
	logic                  op_q;
	logic [LABEL_W-1:0]    row_q;
	logic [LABEL_W-1:0]    col_q;
	logic [PROD_W-1:0]     prod_q;
	logic [ENTRY_W-1:0]    entry_q;
	logic [NORM_W-1:0]     norm_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [AW-1:0]         clr_cnt_q;

	// Output register.
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ENTRY_W-1:0]    ent_out_q;
	logic [TOTAL_W-1:0]    tot_out_q;
	logic [NORM_W-1:0]     norm_out_q;

	logic [AW-1:0]         rc_addr;
	logic [AW-1:0]         cr_addr;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [ENTRY_W-1:0]    rd_data;
	logic [ENTRY_W:0]      entry_sum;
	logic [ENTRY_W-1:0]    entry_new;
	logic [TOTAL_W:0]      total_sum;
	logic [TOTAL_W-1:0]    total_new;
	logic                  row_oor;
	logic                  col_oor;
	logic [STATUS_W-1:0]   status_code;
	logic                  div_done;
	logic [QUOT_W-1:0]     div_quot;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= LABEL_COUNT_RST;
			normalise_q   <= NORMALISE_RST;
			cutoff_q      <= CUTOFF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LABEL_COUNT: label_count_q <= cfg_data[COUNT_W-1:0];
				CFG_NORMALISE:   normalise_q   <= cfg_data[0];
				CFG_CUTOFF:      cutoff_q      <= cfg_data[PROD_W-1:0];
				default: ;
			endcase
		end
	end

	// Matrix addresses of both orientations of the pair.
	assign rc_addr = AW'(32'(row_q) * MAX_L + 32'(col_q));
	assign cr_addr = AW'(32'(col_q) * MAX_L + 32'(row_q));

	// Saturating additions of the product to an entry and twice it to the total.
	always_comb begin
		entry_sum = {1'b0, rd_data} + {{(ENTRY_W+1-PROD_W){1'b0}}, prod_q};
		entry_new = entry_sum[ENTRY_W] ? '1 : entry_sum[ENTRY_W-1:0];
		total_sum = {1'b0, total_q} + {{(TOTAL_W-PROD_W){1'b0}}, prod_q, 1'b0};
		total_new = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
	end

	// Memory port selection: the clearing pass, then the two write-backs.
	always_comb begin
		ram_we    = cmd.clr_step | cmd.wr_rc | cmd.wr_cr;
		ram_waddr = cmd.clr_step ? clr_cnt_q : (cmd.wr_rc ? rc_addr : cr_addr);
		ram_wdata = cmd.clr_step ? '0 : entry_new;
		ram_re    = cmd.rd_rc | cmd.rd_cr;
		ram_raddr = cmd.rd_rc ? rc_addr : cr_addr;
	end

	wlcm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_matrix (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	wlcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (rd_data),
		.den    (total_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Range checks against both the programmed count and the matrix side.
	always_comb begin
		row_oor = ({1'b0, row_q} >= label_count_q) || (32'(row_q) >= MAX_L);
		col_oor = ({1'b0, col_q} >= label_count_q) || (32'(col_q) >= MAX_L);
	end

	// Status code of the result.
	always_comb begin
		priority if (row_oor || col_oor) begin
			status_code = ST_OUT_RANGE;
		end else if (op_q == OP_READ) begin
			status_code = ST_READ_DONE;
		end else if (prod_q > cutoff_q) begin
			status_code = ST_ACCUMULATED;
		end else begin
			status_code = ST_BELOW_CUT;
		end
	end

	// Status towards the controller.
	always_comb begin
		sts.oor       = row_oor || col_oor;
		sts.is_read   = op_q == OP_READ;
		sts.pass      = prod_q > cutoff_q;
		sts.norm_need = (op_q == OP_READ) && normalise_q && (total_q != '0);
		sts.norm_full = {{(TOTAL_W-ENTRY_W){1'b0}}, rd_data} >= total_q;
		sts.div_done  = div_done;
		sts.clr_last  = clr_cnt_q == AW'(DEPTH - 1);
		sts.out_free  = !out_valid_q || out_ready;
	end

	// Running total and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.wr_rc) begin
				total_q <= total_new;
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Item registers and result entry and fraction.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			row_q   <= label_row;
			col_q   <= label_col;
			prod_q  <= {{(PROD_W-WEIGHT_W){1'b0}}, weight_row} *
				{{(PROD_W-WEIGHT_W){1'b0}}, weight_col};
			entry_q <= '0;
			norm_q  <= '0;
		end
		if (cmd.take_read) begin
			entry_q <= rd_data;
			norm_q  <= (sts.norm_need && sts.norm_full) ? NORM_ONE : '0;
		end
		// On a diagonal pair the second write-back holds the final entry.
		if (cmd.wr_rc || (cmd.wr_cr && (row_q == col_q))) begin
			entry_q <= entry_new;
		end
		if (cmd.take_div) begin
			norm_q <= {1'b0, div_quot};
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q   <= status_code;
			ent_out_q  <= entry_q;
			tot_out_q  <= total_q;
			norm_out_q <= norm_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign entry_value      = ent_out_q;
	assign total_weight     = tot_out_q;
	assign normalised_value = norm_out_q;

	// The total only ever grows.
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> total_q >= $past(total_q))
		else $error("running total decreased");

	// A write-back never makes an entry smaller.
	a_entry_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_rc || cmd.wr_cr) |-> entry_new >= rd_data)
		else $error("entry write-back below its old value");

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// An out-of-range result carries a zero entry and a zero fraction.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && sts.oor) |=> (ent_out_q == '0 && norm_out_q == '0))
		else $error("out-of-range result not zero");

endmodule

[rtl/wlcm_ctrl.sv]
// Controller state machine: clearing pass, item sequencing over the matrix
// memory, divider hand-off and output loading.
// Depends on wlcm_pkg.
module wlcm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wlcm_pkg::wlcm_sts_t sts,
	output wlcm_pkg::wlcm_cmd_t cmd
);
	import wlcm_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_RD_DATA,
		S_WR_RC,
		S_RD_CR,
		S_WR_CR,
		S_DIV_WAIT,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	// Command decode from the state and the datapath status.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR:    cmd.clr_step  = 1'b1;
			S_IDLE:     cmd.capture   = in_valid && in_ready_q;
			S_CHECK:    cmd.rd_rc     = !sts.oor;
			S_RD_DATA: begin
				cmd.take_read = 1'b1;
				cmd.div_start = sts.norm_need && !sts.norm_full;
			end
			S_WR_RC:    cmd.wr_rc     = 1'b1;
			S_RD_CR:    cmd.rd_cr     = 1'b1;
			S_WR_CR:    cmd.wr_cr     = 1'b1;
			S_DIV_WAIT: cmd.take_div  = sts.div_done;
			S_OUT:      cmd.load_out  = sts.out_free;
			default: ;
		endcase
	end

	// State and input ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			in_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_CHECK;
						in_ready_q <= 1'b0;
					end
				end
				S_CHECK: begin
					priority if (sts.oor) begin
						state_q <= S_OUT;
					end else if (!sts.is_read && sts.pass) begin
						state_q <= S_WR_RC;
					end else begin
						state_q <= S_RD_DATA;
					end
				end
				S_RD_DATA: begin
					if (sts.norm_need && !sts.norm_full) begin
						state_q <= S_DIV_WAIT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_WR_RC:    state_q <= S_RD_CR;
				S_RD_CR:    state_q <= S_WR_CR;
				S_WR_CR:    state_q <= S_OUT;
				S_DIV_WAIT: begin
					if (sts.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (sts.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;

	// Input is only offered while waiting for an item.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready_q |-> state_q == S_IDLE)
		else $error("input ready outside idle");

	// An accepted item is checked in the very next cycle.
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_CHECK)
		else $error("accepted item not checked");

	// The two write-backs of a pair follow each other with a read between them.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_rc |=> ##1 cmd.wr_cr)
		else $error("second write-back missing");

endmodule

[rtl/weighted_label_cooccurrence_matrix_top.sv]
// Weighted label co-occurrence matrix.
//
// Channels: an input channel (in_valid/in_ready) carries one item per transfer:
// operation, label_row, label_col, weight_row, weight_col. An output channel
// (out_valid/out_ready) returns one result per item: status, entry_value,
// total_weight, normalised_value. A configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes label_count, normalise and cutoff_threshold; it
// is always ready and should be used only while the block is idle.
// Sequence per item: a label out of range goes from the check straight to the
// output; a read or an accumulate below the cutoff only reads its entry; an
// accumulate does two read-modify-writes on the matrix memory, [row][col] then
// [col][row]; a normalised read also waits for the one-bit-a-cycle fraction
// divider. The result is valid the cycle after the last step.
// Reset: the matrix memory is cleared by a pass of one entry a cycle over all
// MAX_LABELS*MAX_LABELS entries (16384 by default), during which no item is
// accepted; configuration writes are taken throughout.
// Stall: a finished result waits in the output register; the block then holds
// the next item's result until the receiver takes the waiting one.
module weighted_label_cooccurrence_matrix_top #(
	parameter int MAX_LABELS = wlcm_pkg::MAX_LABELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [wlcm_pkg::LABEL_W-1:0]    label_row,
	input  logic [wlcm_pkg::LABEL_W-1:0]    label_col,
	input  logic [wlcm_pkg::WEIGHT_W-1:0]   weight_row,
	input  logic [wlcm_pkg::WEIGHT_W-1:0]   weight_col,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wlcm_pkg::STATUS_W-1:0]   status,
	output logic [wlcm_pkg::ENTRY_W-1:0]    entry_value,
	output logic [wlcm_pkg::TOTAL_W-1:0]    total_weight,
	output logic [wlcm_pkg::NORM_W-1:0]     normalised_value,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wlcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wlcm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wlcm_pkg::*;

	wlcm_cmd_t cmd;
	wlcm_sts_t sts;

	// Configuration writes are always accepted and registered directly.
	assign cfg_ready = 1'b1;

	wlcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wlcm_dpath #(
		.MAX_LABELS (MAX_LABELS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.operation        (operation),
		.label_row        (label_row),
		.label_col        (label_col),
		.weight_row       (weight_row),
		.weight_col       (weight_col),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.status           (status),
		.entry_value      (entry_value),
		.total_weight     (total_weight),
		.normalised_value (normalised_value)
	);

endmodule
